### rtl/core/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

    // Fixed-point format of every matrix element and quaternion component.
    localparam int DW = 16;
    localparam int FB = 14;

    // The square-root argument s is positive and below 2^17 when it is used.
    localparam int SF_W  = DW + 3;
    localparam int TR_W  = DW + 2;
    localparam int SW    = DW + 1;
    localparam int RAD_W = SW + FB;
    localparam int SQ_STEPS = (RAD_W + 1) / 2;
    localparam int RN_W  = 2 * SQ_STEPS;
    localparam int ROOT_W = SQ_STEPS;
    localparam int REM_W = ROOT_W + 2;

    // Divider: numerator is |d| * 2^FB + r, denominator is 2r.
    localparam int DIFF_W = DW + 1;
    localparam int MAG_W  = DIFF_W;
    localparam int NUM_W  = MAG_W + FB;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int LANES  = 3;

    localparam int ONE_I = 1 << FB;

    // Quaternion component indexes.
    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    // Branch codes.
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
        logic signed [DW-1:0] qw;
        logic [1:0]           branch_taken;
        logic                 degenerate;
    } out_t;

    // Per-item control carried alongside the arithmetic. Lane l holds the
    // numerator of the l-th component, in ascending order, that is not the
    // square-root component.
    typedef struct packed {
        logic [LANES-1:0][DIFF_W-1:0] d;
        logic [1:0]                   root_sel;
        logic [1:0]                   branch;
        logic                         degen;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [RAD_W-1:0] rad;
    } front_t;

endpackage

`default_nettype wire

### rtl/core/rmq_front.sv
`default_nettype none

module rmq_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire rmq_pkg::in_t    in_data,
    output logic                 out_valid,
    output rmq_pkg::front_t      out_data
);
    import rmq_pkg::*;

    // Stage A: trace and choice of the largest diagonal element.
    logic                   a_valid_reg;
    in_t                    a_m_reg;
    logic signed [TR_W-1:0] a_trace_reg;
    logic                   a_pos_reg;
    logic [1:0]             a_idx_reg;

    logic signed [TR_W-1:0] trace_next;
    logic                   pos_next;
    logic [1:0]             idx_next;
    logic signed [DW-1:0]   diag_max;

    always_comb begin
        trace_next = TR_W'(in_data.m00) + TR_W'(in_data.m11) + TR_W'(in_data.m22);
        pos_next   = trace_next > 0;
        idx_next   = IDX_X;
        diag_max   = in_data.m00;
        if (in_data.m11 > diag_max) begin
            idx_next = IDX_Y;
            diag_max = in_data.m11;
        end
        if (in_data.m22 > diag_max) begin
            idx_next = IDX_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_m_reg     <= in_data;
            a_trace_reg <= trace_next;
            a_pos_reg   <= pos_next;
            a_idx_reg   <= idx_next;
        end
    end

    // Stage B: square-root argument, numerators and lane assignment.
    logic                   b_valid_reg;
    front_t                 b_data_reg;
    front_t                 b_data_next;

    logic signed [DW-1:0]   mii, mjj, mkk;
    logic signed [SF_W-1:0] s_val;
    logic                   degen;
    logic signed [SF_W-1:0] one_s;

    always_comb begin
        one_s = $signed(SF_W'(ONE_I));
        case (a_idx_reg)
            IDX_Y: begin
                mii = a_m_reg.m11; mjj = a_m_reg.m22; mkk = a_m_reg.m00;
            end
            IDX_Z: begin
                mii = a_m_reg.m22; mjj = a_m_reg.m00; mkk = a_m_reg.m11;
            end
            default: begin
                mii = a_m_reg.m00; mjj = a_m_reg.m11; mkk = a_m_reg.m22;
            end
        endcase

        if (a_pos_reg) begin
            s_val = SF_W'(a_trace_reg) + one_s;
        end else begin
            s_val = SF_W'(mii) - SF_W'(mjj) - SF_W'(mkk) + one_s;
        end
        degen = !a_pos_reg && (s_val <= 0);

        b_data_next.side.degen = degen;
        b_data_next.rad = degen ? '0 : {s_val[SW-1:0], {FB{1'b0}}};

        if (a_pos_reg) begin
            b_data_next.side.branch   = BR_TRACE;
            b_data_next.side.root_sel = IDX_W;
            b_data_next.side.d[0] = DIFF_W'(a_m_reg.m21) - DIFF_W'(a_m_reg.m12);
            b_data_next.side.d[1] = DIFF_W'(a_m_reg.m02) - DIFF_W'(a_m_reg.m20);
            b_data_next.side.d[2] = DIFF_W'(a_m_reg.m10) - DIFF_W'(a_m_reg.m01);
        end else begin
            case (a_idx_reg)
                IDX_Y: begin
                    // Lanes carry x, z, w.
                    b_data_next.side.branch   = BR_Y;
                    b_data_next.side.root_sel = IDX_Y;
                    b_data_next.side.d[0] = DIFF_W'(a_m_reg.m01) + DIFF_W'(a_m_reg.m10);
                    b_data_next.side.d[1] = DIFF_W'(a_m_reg.m21) + DIFF_W'(a_m_reg.m12);
                    b_data_next.side.d[2] = DIFF_W'(a_m_reg.m02) - DIFF_W'(a_m_reg.m20);
                end
                IDX_Z: begin
                    // Lanes carry x, y, w.
                    b_data_next.side.branch   = BR_Z;
                    b_data_next.side.root_sel = IDX_Z;
                    b_data_next.side.d[0] = DIFF_W'(a_m_reg.m02) + DIFF_W'(a_m_reg.m20);
                    b_data_next.side.d[1] = DIFF_W'(a_m_reg.m12) + DIFF_W'(a_m_reg.m21);
                    b_data_next.side.d[2] = DIFF_W'(a_m_reg.m10) - DIFF_W'(a_m_reg.m01);
                end
                default: begin
                    // Lanes carry y, z, w.
                    b_data_next.side.branch   = BR_X;
                    b_data_next.side.root_sel = IDX_X;
                    b_data_next.side.d[0] = DIFF_W'(a_m_reg.m10) + DIFF_W'(a_m_reg.m01);
                    b_data_next.side.d[1] = DIFF_W'(a_m_reg.m20) + DIFF_W'(a_m_reg.m02);
                    b_data_next.side.d[2] = DIFF_W'(a_m_reg.m21) - DIFF_W'(a_m_reg.m12);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

`default_nettype wire

### rtl/core/rmq_sqrt.sv
`default_nettype none

module rmq_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire rmq_pkg::front_t            in_data,
    output logic                            out_valid,
    output rmq_pkg::side_t                  out_side,
    output logic [rmq_pkg::ROOT_W-1:0]      out_root
);
    import rmq_pkg::*;

    // One result bit per stage, two radicand bits consumed per stage.
    logic              valid_reg [SQ_STEPS];
    side_t             side_reg  [SQ_STEPS];
    logic [RN_W-1:0]   n_reg     [SQ_STEPS];
    logic [REM_W-1:0]  rem_reg   [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic              v_in;
        side_t             side_in;
        logic [RN_W-1:0]   n_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              take;
        logic [REM_W+1:0]  rem_diff;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_data.side;
            assign n_in    = RN_W'(in_data.rad);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign side_in = side_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_in, n_in[RN_W-1 -: 2]};
            trial     = (REM_W+2)'({root_in, 2'b01});
            take      = rem_sh >= trial;
            rem_diff  = take ? rem_sh - trial : rem_sh;
            rem_next  = rem_diff[REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_in;
                n_reg[k]    <= n_in << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_side  = side_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/rmq_div.sv
`default_nettype none

module rmq_div (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire rmq_pkg::side_t                         in_side,
    input  wire logic [rmq_pkg::ROOT_W-1:0]             in_root,
    output logic                                        out_valid,
    output rmq_pkg::side_t                              out_side,
    output logic [rmq_pkg::ROOT_W-1:0]                  out_root,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] out_quo,
    output logic [rmq_pkg::LANES-1:0]                   out_neg
);
    import rmq_pkg::*;

    // Entry 0 is the operand setup stage; entries 1..NUM_W are the
    // restoring division steps, one quotient bit each.
    localparam int DEPTH = NUM_W + 1;

    logic                          valid_reg [DEPTH];
    side_t                         side_reg  [DEPTH];
    logic [ROOT_W-1:0]             root_reg  [DEPTH];
    logic [DEN_W-1:0]              den_reg   [DEPTH];
    logic [LANES-1:0]              neg_reg   [DEPTH];
    logic [LANES-1:0][NUM_W-1:0]   num_reg   [DEPTH];
    logic [LANES-1:0][DEN_W-1:0]   rem_reg   [DEPTH];
    logic [LANES-1:0][NUM_W-1:0]   quo_reg   [DEPTH];

    logic [LANES-1:0]            neg_next;
    logic [LANES-1:0][NUM_W-1:0] num_next;

    always_comb begin
        logic signed [DIFF_W-1:0] dl;
        logic [MAG_W-1:0]         mag;
        for (int l = 0; l < LANES; l++) begin
            dl          = $signed(in_side.d[l]);
            neg_next[l] = dl[DIFF_W-1];
            mag         = neg_next[l] ? MAG_W'(-dl) : MAG_W'(dl);
            num_next[l] = (NUM_W'(mag) << FB) + NUM_W'(in_root);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            root_reg[0] <= in_root;
            den_reg[0]  <= {in_root, 1'b0};
            neg_reg[0]  <= neg_next;
            num_reg[0]  <= num_next;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
        end
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_step
        logic [LANES-1:0][NUM_W-1:0] num_step;
        logic [LANES-1:0][DEN_W-1:0] rem_step;
        logic [LANES-1:0][NUM_W-1:0] quo_step;

        always_comb begin
            logic [DEN_W:0] rem_sh;
            logic [DEN_W:0] rem_diff;
            logic           take;
            for (int l = 0; l < LANES; l++) begin
                rem_sh      = {rem_reg[k-1][l], num_reg[k-1][l][NUM_W-1]};
                take        = rem_sh >= {1'b0, den_reg[k-1]};
                rem_diff    = take ? rem_sh - {1'b0, den_reg[k-1]} : rem_sh;
                rem_step[l] = rem_diff[DEN_W-1:0];
                quo_step[l] = {quo_reg[k-1][l][NUM_W-2:0], take};
                num_step[l] = num_reg[k-1][l] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
                root_reg[k] <= root_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                num_reg[k]  <= num_step;
                rem_reg[k]  <= rem_step;
                quo_reg[k]  <= quo_step;
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_side  = side_reg[DEPTH-1];
    assign out_root  = root_reg[DEPTH-1];
    assign out_quo   = quo_reg[DEPTH-1];
    assign out_neg   = neg_reg[DEPTH-1];

endmodule

`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion.sv
`default_nettype none

// Channel   Direction  Ports                       Payload
// request   in         s_valid s_ready s_data      nine matrix elements, Q2.14
// result    out        m_valid m_ready m_data      qx qy qz qw, branch, flag
//
// One request is taken every clock cycle unless the pipeline is stalled; each
// result passes through two front-end stages, sixteen square-root stages (one
// root bit each), one divider setup stage, 31 divider stages (one quotient bit
// each) and the output register; the divider is the deepest part.
// Reset (aresetn, synchronous, active low) clears every valid bit.
// The whole pipeline advances together whenever the output register is empty
// or being read, so a stall holds every stage in place and drops nothing.

module rotation_matrix_to_quaternion (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire rmq_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output rmq_pkg::out_t     m_data
);
    import rmq_pkg::*;

    logic en;

    logic   fr_valid;
    front_t fr_data;

    logic              sq_valid;
    side_t             sq_side;
    logic [ROOT_W-1:0] sq_root;

    logic                        dv_valid;
    side_t                       dv_side;
    logic [ROOT_W-1:0]           dv_root;
    logic [LANES-1:0][NUM_W-1:0] dv_quo;
    logic [LANES-1:0]            dv_neg;

    logic m_valid_reg;
    out_t m_data_reg;
    out_t m_data_next;

    // Global advance: the output register is free or is being emptied.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    rmq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    rmq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_root  (dv_root),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg)
    );

    // Final assembly: the root component is the root halved with rounding; each
    // quotient takes its sign back and is saturated to the output range. Lanes
    // fill the non-root components in ascending order; degenerate gives zeros.
    always_comb begin
        logic [ROOT_W:0]       root_half;
        logic [DW-1:0]         root_comp;
        logic [DW-1:0]         lane_val [LANES];
        logic [DW-1:0]         comp     [4];
        logic [NUM_W-1:0]      sat_pos;
        logic [1:0]            oi;
        logic [1:0]            li;

        root_half = (ROOT_W + 1)'(dv_root) + 1'b1;
        root_comp = DW'(root_half >> 1);
        sat_pos   = NUM_W'((1 << (DW - 1)) - 1);

        for (int l = 0; l < LANES; l++) begin
            if (dv_neg[l]) begin
                if (dv_quo[l] > sat_pos + 1'b1) begin
                    lane_val[l] = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    lane_val[l] = DW'(-dv_quo[l]);
                end
            end else begin
                if (dv_quo[l] > sat_pos) begin
                    lane_val[l] = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    lane_val[l] = dv_quo[l][DW-1:0];
                end
            end
        end

        for (int o = 0; o < 4; o++) begin
            oi = 2'(o);
            li = (oi < dv_side.root_sel) ? oi : oi - 2'd1;
            if (dv_side.degen) begin
                comp[o] = '0;
            end else if (oi == dv_side.root_sel) begin
                comp[o] = root_comp;
            end else begin
                comp[o] = lane_val[li];
            end
        end

        m_data_next.qx           = $signed(comp[IDX_X]);
        m_data_next.qy           = $signed(comp[IDX_Y]);
        m_data_next.qz           = $signed(comp[IDX_Z]);
        m_data_next.qw           = $signed(comp[IDX_W]);
        m_data_next.branch_taken = dv_side.branch;
        m_data_next.degenerate   = dv_side.degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import rmq_pkg::*;

    // Results of the block: one quaternion per request, computed in the same
    // Q2.14 format as the matrix elements.
    localparam int RESULT_LATENCY = 51;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    int unsigned mismatch_count;

    // Random idling bursts on each side. They are switched off in the last
    // part of the run so that back-to-back traffic is also covered.
    bit idling_on;

    rotation_matrix_to_quaternion dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Every mismatch is printed on one line and counted.
    task automatic report(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Integer square root of a nonnegative value, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // d * 2^FB / (2r), with the magnitude rounded half up and the sign of d.
    function automatic longint scaled_quotient(input longint d, input longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FB) + r) / (r << 1);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [DW-1:0] saturate(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[DW-1:0];
    endfunction

    // Works out the quaternion that the block must give for one matrix.
    function automatic out_t quaternion_of(input in_t mat);
        longint m [3][3];
        longint q [4];
        longint trace;
        longint s;
        longint unsigned r;
        int i;
        int j;
        int k;
        out_t res;
        m[0][0] = mat.m00; m[0][1] = mat.m01; m[0][2] = mat.m02;
        m[1][0] = mat.m10; m[1][1] = mat.m11; m[1][2] = mat.m12;
        m[2][0] = mat.m20; m[2][1] = mat.m21; m[2][2] = mat.m22;
        for (int n = 0; n < 4; n++) q[n] = 0;
        res.degenerate = 1'b0;
        trace = m[0][0] + m[1][1] + m[2][2];
        if (trace > 0) begin
            s = trace + ONE_I;
            r = int_sqrt(longint'(s) << FB);
            q[IDX_W] = longint'((r + 1) >> 1);
            q[IDX_X] = scaled_quotient(m[2][1] - m[1][2], r);
            q[IDX_Y] = scaled_quotient(m[0][2] - m[2][0], r);
            q[IDX_Z] = scaled_quotient(m[1][0] - m[0][1], r);
            res.branch_taken = BR_TRACE;
        end else begin
            // Ties on the diagonal keep the lower index.
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            res.branch_taken = 2'(i + 1);
            s = m[i][i] - m[j][j] - m[k][k] + ONE_I;
            if (s <= 0) begin
                res.degenerate = 1'b1;
            end else begin
                r = int_sqrt(longint'(s) << FB);
                q[i] = longint'((r + 1) >> 1);
                q[j] = scaled_quotient(m[j][i] + m[i][j], r);
                q[k] = scaled_quotient(m[k][i] + m[i][k], r);
                q[IDX_W] = scaled_quotient(m[k][j] - m[j][k], r);
            end
        end
        res.qx = saturate(q[IDX_X]);
        res.qy = saturate(q[IDX_Y]);
        res.qz = saturate(q[IDX_Z]);
        res.qw = saturate(q[IDX_W]);
        return res;
    endfunction

    // Holds the quaternions still owed by the block, oldest first.
    class quaternion_board;
        out_t owed[$];

        function void note_request(input in_t mat);
            owed.push_back(quaternion_of(mat));
        endfunction

        task check_result(input out_t got);
            out_t want;
            if (owed.size() == 0) begin
                report($sformatf("result with nothing owed: %h", got));
                return;
            end
            want = owed.pop_front();
            if (got.qx !== want.qx)
                report($sformatf("qx got %h want %h", got.qx, want.qx));
            if (got.qy !== want.qy)
                report($sformatf("qy got %h want %h", got.qy, want.qy));
            if (got.qz !== want.qz)
                report($sformatf("qz got %h want %h", got.qz, want.qz));
            if (got.qw !== want.qw)
                report($sformatf("qw got %h want %h", got.qw, want.qw));
            if (got.branch_taken !== want.branch_taken)
                report($sformatf("branch got %0d want %0d",
                                 got.branch_taken, want.branch_taken));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate got %b want %b",
                                 got.degenerate, want.degenerate));
        endtask
    endclass

    quaternion_board board = new();

    // Sends one request. Valid goes up at a rising edge and holds with the
    // payload until the block takes it. An optional gap comes first, and
    // valid drops only for such a gap, so back-to-back requests keep it high.
    task automatic send_request(input in_t mat);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= mat;
        do @(posedge aclk); while (!s_ready);
        board.note_request(mat);
    endtask

    // Result side: ready is toggled in bursts while idling is on.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_data);
        end
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    function automatic logic signed [DW-1:0] any_element();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(ONE_I);
            3: return -16'(ONE_I);
            4: return 16'(0);
            default: return 16'($urandom());
        endcase
    endfunction

    // Builds a matrix with all nine elements given by fill_mode:
    // 0 fully random, 1 small values from -1.0 to 1.0, 2 extremes mixed in.
    function automatic in_t random_matrix(input int fill_mode);
        in_t mat;
        logic signed [DW-1:0] e [9];
        for (int n = 0; n < 9; n++) begin
            case (fill_mode)
                0: e[n] = 16'($urandom());
                1: e[n] = 16'(int'($urandom_range(0, 2 * ONE_I)) - ONE_I);
                default: e[n] = any_element();
            endcase
        end
        mat = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return mat;
    endfunction

    function automatic in_t diag_matrix(input int a, input int b, input int c);
        in_t mat;
        mat = '0;
        mat.m00 = 16'(a);
        mat.m11 = 16'(b);
        mat.m22 = 16'(c);
        return mat;
    endfunction

    initial begin
        in_t mat;
        mismatch_count = 0;
        idling_on = 1'b1;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: identity, each axis branch, ties on the diagonal
        // and full-scale elements.
        send_request(diag_matrix(ONE_I, ONE_I, ONE_I));
        send_request(diag_matrix(ONE_I, -ONE_I, -ONE_I));
        send_request(diag_matrix(-ONE_I, ONE_I, -ONE_I));
        send_request(diag_matrix(-ONE_I, -ONE_I, ONE_I));
        send_request(diag_matrix(0, 0, 0));
        send_request(diag_matrix(-ONE_I, -ONE_I, -ONE_I));
        send_request(diag_matrix(-100, -100, -100));
        send_request(diag_matrix(-5000, -5000, 2000));
        send_request(diag_matrix(-32768, -32768, -32768));
        send_request(diag_matrix(32767, 32767, 32767));
        send_request(diag_matrix(32767, -32768, -32768));
        send_request(diag_matrix(-32768, -32768, 32767));
        mat = '1;
        send_request(mat);
        mat = {9{16'sh8000}};
        send_request(mat);
        mat = {9{16'sh7fff}};
        send_request(mat);
        mat = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
               16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_request(mat);
        mat = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
               16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_request(mat);
        // Full-scale off-diagonal elements through the y-axis branch.
        mat = diag_matrix(-8192, -4096, -4096);
        mat.m01 = 16'sh7fff;
        mat.m10 = 16'sh7fff;
        mat.m21 = 16'sh8000;
        send_request(mat);
        s_valid <= 1'b0;

        // The sender holds off until the block has drained.
        wait (board.owed.size() == 0);

        for (int n = 0; n < 450; n++) begin
            if (n == 380) idling_on = 1'b0;
            send_request(random_matrix($urandom_range(0, 2)));
        end
        s_valid <= 1'b0;

        wait (board.owed.size() == 0);
        repeat (RESULT_LATENCY + 10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Worst case is far below this: every request and result can wait out
    // the longest idling burst plus the pipeline depth.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
sim/tb.sv
